### rtl/core/assert_macros.svh
// Concurrent check macros. Each check is sampled on the rising edge of clk;
// TCFS_ASSERT checks are held off while rst_n is low, TCFS_ASSERT_NORST ones are not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define TCFS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcfs check failed");
`define TCFS_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("tcfs check failed");
`else
`define TCFS_ASSERT(lbl, prop)
`define TCFS_ASSERT_NORST(lbl, prop)
`endif

`endif

### rtl/core/tcfs_pkg.sv
package tcfs_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int TAG_W       = 64;
  localparam int SLOT_W      = 8;
  localparam int FREED_W     = 9;

  localparam logic [FREED_W-1:0] FREED_MAX = 9'd511;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  // One table entry as it travels around the ring.
  typedef struct packed {
    logic             valid;
    logic             seen;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Controls broadcast from the head to every cell.
  typedef struct packed {
    logic             shift;
    logic             upd_en;
    logic             upd_wr_tag;
    logic [TAG_W-1:0] upd_tag;
  } ring_ctl_t;

endpackage

### rtl/core/tcfs_cell.sv
module tcfs_cell
  import tcfs_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int POS     = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ring_ctl_t                  ctl,
  input  logic [$clog2(ENTRIES)-1:0] upd_idx,
  input  entry_t                     ent_in,
  output entry_t                     ent_out
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(POS);

  logic             valid_r;
  logic             seen_r;
  logic [TAG_W-1:0] tag_r;
  logic             upd_here;

  // The update is applied only while the ring stands still and is aligned.
  assign upd_here = ctl.upd_en && (upd_idx == POS_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      seen_r  <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= ent_in.valid;
      seen_r  <= ent_in.seen;
    end else if (upd_here) begin
      valid_r <= 1'b1;
      seen_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      tag_r <= ent_in.tag;
    end else if (upd_here && ctl.upd_wr_tag) begin
      tag_r <= ctl.upd_tag;
    end
  end

  assign ent_out = '{valid: valid_r, seen: seen_r, tag: tag_r};

endmodule

### rtl/core/tcfs_ctrl.sv
module tcfs_ctrl
  import tcfs_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [TAG_W-1:0]           in_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic [SLOT_W-1:0]          out_slot,
  output logic                       out_stored,
  output logic                       out_replaced,
  output logic [FREED_W-1:0]         out_freed_count,
  input  entry_t                     head,
  output entry_t                     ret,
  output ring_ctl_t                  ctl,
  output logic [$clog2(ENTRIES)-1:0] upd_idx
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]         state_r,     state_nxt;
  logic [IDX_W-1:0]   cnt_r,       cnt_nxt;
  logic               op_r,        op_nxt;
  logic [TAG_W-1:0]   key_r,       key_nxt;
  logic               found_v_r,   found_v_nxt;
  logic [IDX_W-1:0]   found_idx_r, found_idx_nxt;
  logic               free_v_r,    free_v_nxt;
  logic [IDX_W-1:0]   free_idx_r,  free_idx_nxt;
  logic               stale_v_r,   stale_v_nxt;
  logic [IDX_W-1:0]   stale_idx_r, stale_idx_nxt;
  logic [FREED_W-1:0] freed_r,     freed_nxt;

  logic               out_valid_r,    out_valid_nxt;
  logic               out_hit_r,      out_hit_nxt;
  logic [SLOT_W-1:0]  out_slot_r,     out_slot_nxt;
  logic               out_stored_r,   out_stored_nxt;
  logic               out_replaced_r, out_replaced_nxt;
  logic [FREED_W-1:0] out_freed_r,    out_freed_nxt;

  logic               in_take;
  logic               out_free;
  logic               fin_go;
  logic               lk_has_target;
  logic [IDX_W-1:0]   target_idx;
  logic [IDX_W-1:0]   res_idx;
  logic [IDX_W+SLOT_W-1:0] res_idx_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign fin_go    = (state_r == S_FIN) && out_free;

  assign lk_has_target = free_v_r || stale_v_r;
  assign target_idx    = free_v_r ? free_idx_r : stale_idx_r;
  assign res_idx       = found_v_r ? found_idx_r : target_idx;
  assign res_idx_ext   = {{SLOT_W{1'b0}}, res_idx};

  // Ring control: rotate during the scan, and for a lookup one targeted write at the end.
  always_comb begin
    ctl.shift      = (state_r == S_SCAN);
    ctl.upd_en     = fin_go && (op_r == OP_LOOKUP) && (found_v_r || lk_has_target);
    ctl.upd_wr_tag = !found_v_r;
    ctl.upd_tag    = key_r;
    upd_idx        = res_idx;
  end

  // The sweep rewrites each entry as it passes the head; lookups leave it intact.
  always_comb begin
    ret = head;
    if (op_r == OP_SWEEP) begin
      ret.valid = head.valid && head.seen;
      ret.seen  = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    found_v_nxt   = found_v_r;
    found_idx_nxt = found_idx_r;
    free_v_nxt    = free_v_r;
    free_idx_nxt  = free_idx_r;
    stale_v_nxt   = stale_v_r;
    stale_idx_nxt = stale_idx_r;
    freed_nxt     = freed_r;

    out_valid_nxt    = out_valid_r && out_stall;
    out_hit_nxt      = out_hit_r;
    out_slot_nxt     = out_slot_r;
    out_stored_nxt   = out_stored_r;
    out_replaced_nxt = out_replaced_r;
    out_freed_nxt    = out_freed_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt   = S_SCAN;
          cnt_nxt     = '0;
          op_nxt      = in_op;
          key_nxt     = in_key;
          found_v_nxt = 1'b0;
          free_v_nxt  = 1'b0;
          stale_v_nxt = 1'b0;
          freed_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (op_r == OP_SWEEP) begin
          if (head.valid && !head.seen && (freed_r != FREED_MAX)) begin
            freed_nxt = freed_r + 1'b1;
          end
        end else if (head.valid) begin
          if (!found_v_r && (head.tag == key_r)) begin
            found_v_nxt   = 1'b1;
            found_idx_nxt = cnt_r;
          end
          if (!stale_v_r && !head.seen) begin
            stale_v_nxt   = 1'b1;
            stale_idx_nxt = cnt_r;
          end
        end else if (!free_v_r) begin
          free_v_nxt   = 1'b1;
          free_idx_nxt = cnt_r;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (op_r == OP_SWEEP) begin
            out_hit_nxt      = 1'b0;
            out_slot_nxt     = '0;
            out_stored_nxt   = 1'b0;
            out_replaced_nxt = 1'b0;
            out_freed_nxt    = freed_r;
          end else begin
            out_hit_nxt      = found_v_r;
            out_slot_nxt     = (found_v_r || lk_has_target) ? res_idx_ext[SLOT_W-1:0] : '0;
            out_stored_nxt   = !found_v_r && lk_has_target;
            out_replaced_nxt = !found_v_r && !free_v_r && stale_v_r;
            out_freed_nxt    = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    key_r          <= key_nxt;
    found_v_r      <= found_v_nxt;
    found_idx_r    <= found_idx_nxt;
    free_v_r       <= free_v_nxt;
    free_idx_r     <= free_idx_nxt;
    stale_v_r      <= stale_v_nxt;
    stale_idx_r    <= stale_idx_nxt;
    freed_r        <= freed_nxt;
    out_hit_r      <= out_hit_nxt;
    out_slot_r     <= out_slot_nxt;
    out_stored_r   <= out_stored_nxt;
    out_replaced_r <= out_replaced_nxt;
    out_freed_r    <= out_freed_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_stored      = out_stored_r;
  assign out_replaced    = out_replaced_r;
  assign out_freed_count = out_freed_r;

`include "assert_macros.svh"

  `TCFS_ASSERT(a_take_then_busy, in_take |=> in_stall)
  `TCFS_ASSERT(a_idle_aligned, (state_r == S_IDLE) |-> (cnt_r == '0))
  `TCFS_ASSERT(a_hit_xor_store, out_valid_r |-> !(out_hit_r && out_stored_r))
  `TCFS_ASSERT(a_replace_needs_store, (out_valid_r && out_replaced_r) |-> out_stored_r)
  `TCFS_ASSERT(a_sweep_fields, (out_valid_r && (out_freed_r != '0)) |-> (!out_hit_r && !out_stored_r && (out_slot_r == '0)))

endmodule

### rtl/core/tagged_cache_frame_sweep_top.sv
// Channel  | Ports                                               | Direction
// -------- | --------------------------------------------------- | ---------
// input    | in_valid, in_stall, in_op, in_key                   | in
// result   | out_valid, out_stall, out_hit, out_slot, out_stored,| out
//          | out_replaced, out_freed_count                       |
//
// An item is latched on acceptance; then the whole ring of ENTRIES cells is
// rotated past the single tag comparator at its head; then the result is
// written back and registered. The next item is accepted only after that.
// in_stall stays high until the result is registered.
// A stalled result holds in the output register; the next item is accepted
// meanwhile, and its final cycle waits until that register is free.
// rst_n (synchronous) clears every valid and seen mark at once.
module tagged_cache_frame_sweep_top
  import tcfs_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [TAG_W-1:0]   in_key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_stored,
  output logic               out_replaced,
  output logic [FREED_W-1:0] out_freed_count
);

  localparam int IDX_W = $clog2(ENTRIES);

  entry_t           ent_q [ENTRIES];
  entry_t           ret;
  ring_ctl_t        ctl;
  logic [IDX_W-1:0] upd_idx;

  tcfs_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_stored      (out_stored),
    .out_replaced    (out_replaced),
    .out_freed_count (out_freed_count),
    .head            (ent_q[0]),
    .ret             (ret),
    .ctl             (ctl),
    .upd_idx         (upd_idx)
  );

  // Ring: each cell takes its upper neighbor; the last cell takes the head's return.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t ent_in;
    if (i == ENTRIES - 1) begin : g_last
      assign ent_in = ret;
    end else begin : g_mid
      assign ent_in = ent_q[i+1];
    end
    tcfs_cell #(
      .ENTRIES (ENTRIES),
      .POS     (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .upd_idx (upd_idx),
      .ent_in  (ent_in),
      .ent_out (ent_q[i])
    );
  end

endmodule

### verif/tb_tagged_cache_frame_sweep_top.sv
`timescale 1ns / 1ps

module tb_tagged_cache_frame_sweep_top;
  import tcfs_pkg::*;

  localparam int ENTRIES     = ENTRIES_DEF;
  localparam int HOLD_CYCLES = 1500;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               stored;
    logic               replaced;
    logic [FREED_W-1:0] freed;
  } cache_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_op = OP_LOOKUP;
  logic [TAG_W-1:0]   in_key = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_stored;
  logic               out_replaced;
  logic [FREED_W-1:0] out_freed_count;

  // Shadow copy of the table
  bit               tbl_valid [ENTRIES];
  logic [TAG_W-1:0] tbl_tag   [ENTRIES];
  bit               tbl_seen  [ENTRIES];

  cache_result_t tag_results_q [$];

  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_hits = 0;
  int n_inserts = 0;
  int n_displaced = 0;
  int n_dropped = 0;
  int n_sweeps = 0;
  int max_freed = 0;

  bit no_gaps = 1'b0;
  bit no_stalls = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int stall_left = 0;
  int stall_pick;

  tagged_cache_frame_sweep_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_slot       (out_slot),
    .out_stored     (out_stored),
    .out_replaced   (out_replaced),
    .out_freed_count(out_freed_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               tag_results_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Apply one transaction to the shadow table and return what the block must report.
  function automatic cache_result_t apply_to_table(logic op, logic [TAG_W-1:0] key);
    cache_result_t res;
    int found;
    int free_idx;
    int stale_idx;
    int target;
    int freed;
    res = '0;
    found = -1;
    free_idx = -1;
    stale_idx = -1;
    freed = 0;
    n_items++;
    if (op == OP_SWEEP) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i] && !tbl_seen[i]) begin
          tbl_valid[i] = 1'b0;
          if (freed < int'(FREED_MAX)) freed++;
        end
        tbl_seen[i] = 1'b0;
      end
      res.freed = freed[FREED_W-1:0];
      n_sweeps++;
      if (freed > max_freed) max_freed = freed;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i]) begin
          if (found < 0 && tbl_tag[i] == key) found = i;
          if (stale_idx < 0 && !tbl_seen[i]) stale_idx = i;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (found >= 0) begin
        tbl_seen[found] = 1'b1;
        res.hit = 1'b1;
        res.slot = found[SLOT_W-1:0];
        n_hits++;
      end else begin
        target = (free_idx >= 0) ? free_idx : stale_idx;
        if (target < 0) begin
          n_dropped++;
        end else begin
          res.slot = target[SLOT_W-1:0];
          res.stored = 1'b1;
          res.replaced = tbl_valid[target];
          if (tbl_valid[target]) n_displaced++;
          n_inserts++;
          tbl_valid[target] = 1'b1;
          tbl_tag[target] = key;
          tbl_seen[target] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic int resident_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) if (tbl_valid[i]) n++;
    return n;
  endfunction

  function automatic bit pick_resident(output int idx);
    int cand [$];
    idx = 0;
    for (int i = 0; i < ENTRIES; i++) if (tbl_valid[i]) cand.push_back(i);
    if (cand.size() == 0) return 1'b0;
    idx = cand[$urandom_range(0, cand.size() - 1)];
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input logic op, input logic [TAG_W-1:0] key);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tag_results_q.push_back(apply_to_table(op, key));
  endtask

  // Look up either a resident tag (hit_pct percent of the time) or a fresh random one.
  task automatic random_lookup(input int hit_pct);
    logic [TAG_W-1:0] key;
    int idx;
    key = {$urandom(), $urandom()};
    if ($urandom_range(0, 99) < hit_pct && pick_resident(idx)) key = tbl_tag[idx];
    send_item(OP_LOOKUP, key);
  endtask

  // Receiver: random hold-offs, plus one long hold on request.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && !no_stalls) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick >= 95) stall_left = $urandom_range(10, 40);
      else if (stall_pick >= 72) stall_left = $urandom_range(1, 3);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cache_result_t got;
    cache_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_hit, out_slot, out_stored, out_replaced, out_freed_count};
      if (tag_results_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result hit=%0d slot=%0d stored=%0d replaced=%0d freed=%0d",
                 $time, got.hit, got.slot, got.stored, got.replaced, got.freed);
      end else begin
        want = tag_results_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected hit=%0d slot=%0d stored=%0d replaced=%0d freed=%0d",
                   $time, want.hit, want.slot, want.stored, want.replaced, want.freed);
          $display("%0t:          actual   hit=%0d slot=%0d stored=%0d replaced=%0d freed=%0d",
                   $time, got.hit, got.slot, got.stored, got.replaced, got.freed);
        end
      end
    end
  end

  task automatic test_directed();
    send_item(OP_SWEEP, 64'hFFFF_FFFF_FFFF_FFFF);   // sweep of an empty table
    send_item(OP_LOOKUP, 64'h0000_0000_0000_0000);
    send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_LOOKUP, 64'h0000_0000_0000_0000);  // hit
    send_item(OP_LOOKUP, 64'h8000_0000_0000_0001);
    send_item(OP_LOOKUP, 64'h0000_0000_0000_0001);
    send_item(OP_SWEEP, '0);                        // all seen: frees nothing
    send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_SWEEP, '0);                        // frees everything but the hit
    send_item(OP_LOOKUP, 64'h5555_5555_5555_5555);  // refill lowest free slot
    send_item(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_SWEEP, '0);
    send_item(OP_SWEEP, '0);
    send_item(OP_SWEEP, '0);
  endtask

  task automatic test_full_table();
    while (resident_count() < ENTRIES) random_lookup(8);
    // full and every entry seen: misses are dropped
    repeat (3) send_item(OP_LOOKUP, {$urandom(), $urandom()});
    random_lookup(100);
    send_item(OP_SWEEP, '0);
    // full with nothing seen: misses displace stale entries
    repeat (10) random_lookup(50);
    send_item(OP_SWEEP, '0);
    // only the touched entries are left, none seen: they all go
    send_item(OP_SWEEP, {$urandom(), $urandom()});
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i % 3 == 2) send_item(OP_SWEEP, {$urandom(), $urandom()});
      else random_lookup(50);
    end
  endtask

  task automatic test_random_frames();
    int start;
    int frame;
    int len;
    int hit_pct;
    start = n_items;
    frame = 0;
    while (n_items - start < 100) begin
      len = $urandom_range(1, 24);
      hit_pct = $urandom_range(0, 90);
      no_gaps = (frame % 4 == 3);
      no_stalls = (frame % 4 == 3);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 5)
          send_item(1'($urandom_range(0, 1)), {$urandom(), $urandom()});
        else
          random_lookup(hit_pct);
      end
      send_item(OP_SWEEP, {$urandom(), $urandom()});
      if ($urandom_range(0, 9) == 0) send_item(OP_SWEEP, '0);
      frame++;
    end
    no_gaps = 1'b0;
    no_stalls = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_tag[i] = '0;
      tbl_seen[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_table();
    test_backpressure();
    test_random_frames();

    @(negedge clk);
    in_valid <= 1'b0;
    while (tag_results_q.size() != 0) @(posedge clk);
    repeat (2 * ENTRIES + 10) @(posedge clk);

    $display("Checked %0d transactions: %0d hits, %0d inserts (%0d over stale entries), %0d dropped",
             n_items, n_hits, n_inserts, n_displaced, n_dropped);
    $display("%0d frame sweeps, largest freed %0d; one receiver hold of %0d cycles",
             n_sweeps, max_freed, HOLD_CYCLES);
    if (errors == 0 && tag_results_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
